[rtl/core/tbsp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tbsp_pkg;

  localparam int unsigned PositionBits = 32;
  localparam int unsigned PosW         = PositionBits + 1;
  localparam int unsigned TagLen       = 6;
  localparam int unsigned HeaderLen    = 10;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_LENGTH = 2'd1,
    PH_BODY   = 2'd2
  } phase_e;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SHORT   = 2'd1;
  localparam logic [1:0] ST_OVERRUN = 2'd2;
  localparam logic [1:0] ST_NOBLOCK = 2'd3;

  localparam logic KIND_BLOCK = 1'b0;
  localparam logic KIND_FINAL = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_beat_t;

  typedef struct packed {
    logic        record_kind;
    logic [31:0] block_number;
    logic [31:0] body_offset;
    logic [31:0] body_length;
    logic [31:0] byte_sum;
    logic [1:0]  parse_status;
    logic [31:0] blocks_found;
    logic        last_record;
  } out_beat_t;

  function automatic logic [7:0] tag_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h42;
      3'd1:    b = 8'h4C;
      3'd2:    b = 8'h4F;
      3'd3:    b = 8'h43;
      3'd4:    b = 8'h4B;
      3'd5:    b = 8'h20;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

[rtl/core/tagged_block_stream_parser.sv]
// A record enters a registered output queue when the byte that causes it is accepted.
// Throughput: one byte per cycle unless stalled; a final byte that also closes a
//   block gives two records, popped one per unstalled cycle from a 3-entry queue.
// Input stall rises while two or more records wait in that queue.
// Reset: parser state returns to tag hunt, all counters clear, queue empties.
`timescale 1ns / 1ps
`default_nettype none

module tagged_block_stream_parser (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_stall_o,
  input  wire tbsp_pkg::in_beat_t  in_data_i,
  output logic                     out_valid_o,
  input  wire                      out_stall_i,
  output tbsp_pkg::out_beat_t      out_data_o
);
  import tbsp_pkg::*;

  localparam logic [PosW-1:0] PosMax = '1;

  phase_e          phase_q, phase_d;
  logic [2:0]      tag_q, tag_d;
  logic [1:0]      lbs_q, lbs_d;
  logic [31:0]     len_q, len_d;
  logic [31:0]     rem_q, rem_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] start_q, start_d;
  logic [31:0]     sum_q, sum_d;
  logic [31:0]     cnt_q, cnt_d;

  out_beat_t       queue_q [3];
  out_beat_t       queue_d [3];
  logic [1:0]      fill_q, fill_d;

  logic            accept, pop;
  logic [7:0]      b;
  logic            fin;
  logic            blk_emit;
  logic [31:0]     len_new;
  logic [31:0]     rem_new;
  logic [PosW+31:0] start_ext;
  out_beat_t       blk_rec, fin_rec, res0, res1;
  logic [1:0]      n_res, base;
  logic [1:0]      status;

  assign accept      = in_valid_i && !in_stall_o;
  assign pop         = out_valid_o && !out_stall_i;
  assign in_stall_o  = fill_q >= 2'd2;
  assign out_valid_o = fill_q != 2'd0;
  assign out_data_o  = queue_q[0];
  assign b           = in_data_i.data_byte;
  assign fin         = in_data_i.final_byte;

  always_comb begin
    phase_d  = phase_q;
    tag_d    = tag_q;
    lbs_d    = lbs_q;
    len_d    = len_q;
    rem_d    = rem_q;
    start_d  = start_q;
    sum_d    = sum_q;
    cnt_d    = cnt_q;
    blk_emit = 1'b0;
    len_new  = len_q;
    rem_new  = rem_q - 32'd1;
    pos_d    = (pos_q != PosMax) ? pos_q + PosW'(1) : pos_q;
    case (lbs_q)
      2'd0:    len_new = len_q | {24'd0, b};
      2'd1:    len_new = len_q | {16'd0, b, 8'd0};
      2'd2:    len_new = len_q | {8'd0, b, 16'd0};
      default: len_new = len_q | {b, 24'd0};
    endcase

    unique case (phase_q)
      PH_HUNT: begin
        if (tag_q < 3'(TagLen) && b == tag_byte(tag_q)) begin
          tag_d = tag_q + 3'd1;
        end else begin
          tag_d = (b == tag_byte(3'd0)) ? 3'd1 : 3'd0;
        end
        if (tag_d >= 3'(TagLen)) begin
          tag_d   = 3'd0;
          phase_d = PH_LENGTH;
          lbs_d   = 2'd0;
          len_d   = 32'd0;
        end
      end
      PH_LENGTH: begin
        len_d = len_new;
        if (lbs_q == 2'd3) begin
          lbs_d   = 2'd0;
          start_d = pos_d;
          rem_d   = len_new;
          if (len_new == 32'd0) begin
            blk_emit = 1'b1;
            phase_d  = PH_HUNT;
          end else begin
            phase_d = PH_BODY;
          end
        end else begin
          lbs_d = lbs_q + 2'd1;
        end
      end
      PH_BODY: begin
        sum_d = sum_q + {24'd0, b};
        rem_d = rem_new;
        if (rem_new == 32'd0) begin
          blk_emit = 1'b1;
          phase_d  = PH_HUNT;
          tag_d    = 3'd0;
        end
      end
      default: begin
        phase_d = PH_HUNT;
      end
    endcase

    start_ext = {32'd0, start_d};
    blk_rec              = '0;
    blk_rec.record_kind  = KIND_BLOCK;
    blk_rec.block_number = cnt_q;
    blk_rec.body_offset  = start_ext[31:0];
    blk_rec.body_length  = len_d;
    blk_rec.byte_sum     = sum_d;
    if (blk_emit) begin
      cnt_d = cnt_q + 32'd1;
    end

    if (pos_d < PosW'(HeaderLen)) begin
      status = ST_SHORT;
    end else if (phase_d == PH_BODY) begin
      status = ST_OVERRUN;
    end else if (cnt_d == 32'd0) begin
      status = ST_NOBLOCK;
    end else begin
      status = ST_OK;
    end
    fin_rec              = '0;
    fin_rec.record_kind  = KIND_FINAL;
    fin_rec.byte_sum     = sum_d;
    fin_rec.parse_status = status;
    fin_rec.blocks_found = cnt_d;
    fin_rec.last_record  = 1'b1;

    if (fin) begin
      phase_d = PH_HUNT;
      tag_d   = 3'd0;
      lbs_d   = 2'd0;
      len_d   = 32'd0;
      rem_d   = 32'd0;
      pos_d   = '0;
      start_d = '0;
      sum_d   = 32'd0;
      cnt_d   = 32'd0;
    end
  end

  always_comb begin
    res0  = blk_emit ? blk_rec : fin_rec;
    res1  = fin_rec;
    n_res = accept ? ({1'b0, blk_emit} + {1'b0, fin}) : 2'd0;
    base  = fill_q - {1'b0, pop};
    for (int i = 0; i < 3; i++) begin
      queue_d[i] = queue_q[i];
      if (pop && i < 2) begin
        queue_d[i] = queue_q[i + 1];
      end
      if (n_res != 2'd0 && base == 2'(i)) begin
        queue_d[i] = res0;
      end
      if (n_res == 2'd2 && base + 2'd1 == 2'(i)) begin
        queue_d[i] = res1;
      end
    end
    fill_d = base + n_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      tag_q   <= 3'd0;
      lbs_q   <= 2'd0;
      len_q   <= 32'd0;
      rem_q   <= 32'd0;
      pos_q   <= '0;
      start_q <= '0;
      sum_q   <= 32'd0;
      cnt_q   <= 32'd0;
      fill_q  <= 2'd0;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        tag_q   <= tag_d;
        lbs_q   <= lbs_d;
        len_q   <= len_d;
        rem_q   <= rem_d;
        pos_q   <= pos_d;
        start_q <= start_d;
        sum_q   <= sum_d;
        cnt_q   <= cnt_d;
      end
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    queue_q <= queue_d;
  end

endmodule

`default_nettype wire

[rtl/core/tbsp_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module tbsp_checker (
  input wire                      clk_i,
  input wire                      rst_ni,
  input wire                      in_valid_i,
  input wire                      in_stall_o,
  input wire tbsp_pkg::in_beat_t  in_data_i,
  input wire                      out_valid_o,
  input wire                      out_stall_i,
  input wire tbsp_pkg::out_beat_t out_data_o
);
  import tbsp_pkg::*;

  // hold a stalled beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed");

  // a final byte always leaves a record waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.final_byte |=> out_valid_o)
    else $error("final byte gave no record");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.record_kind == KIND_BLOCK |->
      !out_data_o.last_record && out_data_o.parse_status == ST_OK &&
      out_data_o.blocks_found == 32'd0)
    else $error("block record carries summary fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.record_kind == KIND_FINAL |->
      out_data_o.last_record && out_data_o.block_number == 32'd0 &&
      out_data_o.body_offset == 32'd0 && out_data_o.body_length == 32'd0)
    else $error("final record carries block fields");

endmodule

bind tagged_block_stream_parser tbsp_checker u_tbsp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

import tbsp_pkg::*;

class parse_scoreboard;
  phase_e          phase;
  logic [2:0]      tag_idx;
  logic [1:0]      len_idx;
  logic [31:0]     len_acc;
  logic [31:0]     body_left;
  logic [PosW-1:0] pos;
  logic [PosW-1:0] blk_offset;
  logic [31:0]     sum;
  logic [31:0]     blocks;
  out_beat_t       expected_records[$];
  int unsigned     mismatches;

  function new();
    mismatches = 0;
    clear();
  endfunction

  static function logic [7:0] tag_char(int unsigned i);
    logic [47:0] word;
    word = "BLOCK ";
    return word[47 - 8 * i -: 8];
  endfunction

  function void clear();
    phase      = PH_HUNT;
    tag_idx    = '0;
    len_idx    = '0;
    len_acc    = '0;
    body_left  = '0;
    pos        = '0;
    blk_offset = '0;
    sum        = '0;
    blocks     = '0;
  endfunction

  function int unsigned pending();
    return expected_records.size();
  endfunction

  function void push_block();
    out_beat_t rec;
    rec              = '0;
    rec.record_kind  = KIND_BLOCK;
    rec.block_number = blocks;
    rec.body_offset  = blk_offset[31:0];
    rec.body_length  = len_acc;
    rec.byte_sum     = sum;
    expected_records = {expected_records, rec};
    blocks = blocks + 1;
  endfunction

  function void note_byte(in_beat_t beat);
    logic [PosW-1:0] cur;
    logic [7:0]      b;
    out_beat_t       rec;
    b   = beat.data_byte;
    cur = pos;
    if (pos != '1) pos = pos + 1'b1;
    case (phase)
      PH_HUNT: begin
        if (tag_idx < TagLen && b == tag_char(tag_idx)) tag_idx = tag_idx + 1'b1;
        else tag_idx = (b == tag_char(0)) ? 3'd1 : 3'd0;
        if (tag_idx >= TagLen) begin
          tag_idx = '0;
          phase   = PH_LENGTH;
          len_idx = '0;
          len_acc = '0;
        end
      end
      PH_LENGTH: begin
        len_acc = len_acc | (32'(b) << (8 * len_idx));
        if (len_idx == 2'd3) begin
          len_idx    = '0;
          blk_offset = (cur != '1) ? cur + 1'b1 : cur;
          body_left  = len_acc;
          if (body_left == 0) begin
            push_block();
            phase = PH_HUNT;
          end else begin
            phase = PH_BODY;
          end
        end else begin
          len_idx = len_idx + 1'b1;
        end
      end
      default: begin
        sum       = sum + 32'(b);
        body_left = body_left - 1;
        if (body_left == 0) begin
          push_block();
          phase   = PH_HUNT;
          tag_idx = '0;
        end
      end
    endcase
    if (beat.final_byte) begin
      rec             = '0;
      rec.record_kind = KIND_FINAL;
      rec.byte_sum    = sum;
      rec.blocks_found = blocks;
      rec.last_record = 1'b1;
      if (pos < HeaderLen) rec.parse_status = ST_SHORT;
      else if (phase == PH_BODY && body_left != 0) rec.parse_status = ST_OVERRUN;
      else if (blocks == 0) rec.parse_status = ST_NOBLOCK;
      else rec.parse_status = ST_OK;
      expected_records = {expected_records, rec};
      clear();
    end
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  function void check_record(out_beat_t got);
    out_beat_t want;
    if (expected_records.size() == 0) begin
      $error("record with no expectation: %p", got);
      mismatches++;
      return;
    end
    want = expected_records.pop_front();
    compare_field("record_kind", 32'(want.record_kind), 32'(got.record_kind));
    compare_field("block_number", want.block_number, got.block_number);
    compare_field("body_offset", want.body_offset, got.body_offset);
    compare_field("body_length", want.body_length, got.body_length);
    compare_field("byte_sum", want.byte_sum, got.byte_sum);
    compare_field("parse_status", 32'(want.parse_status), 32'(got.parse_status));
    compare_field("blocks_found", want.blocks_found, got.blocks_found);
    compare_field("last_record", 32'(want.last_record), 32'(got.last_record));
  endfunction
endclass

module testbench;
  localparam int unsigned IdleLimit   = 1000;
  localparam int unsigned TargetBytes = 1150;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_beat_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_beat_t out_data_o;

  parse_scoreboard sb = new();
  logic [7:0]      file_bytes[$];
  bit              quiet = 1'b0;
  bit              took;
  int unsigned     idle_count = 0;
  int unsigned     stall_left = 0;
  int unsigned     bytes_sent = 0;

  tagged_block_stream_parser dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .out_valid_o,
    .out_stall_i,
    .out_data_o
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [7:0] file_tag_char(int unsigned i);
    logic [47:0] word;
    word = "BLOCK ";
    return word[47 - 8 * i -: 8];
  endfunction

  function automatic int unsigned gap_cycles(int unsigned short_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < short_pct) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
      stall_left = gap_cycles(65);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      took = 1'b0;
      if (in_valid_i && !in_stall_o) begin
        sb.note_byte(in_data_i);
        took = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        sb.check_record(out_data_o);
        took = 1'b1;
      end
      idle_count = took ? 0 : idle_count + 1;
      if (idle_count >= IdleLimit) begin
        $display("tagged_block_stream_parser regression: fail");
        $finish;
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic fin);
    in_beat_t beat;
    int unsigned gap;
    gap  = gap_cycles(70);
    beat = '{data_byte: b, final_byte: fin};
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
  endtask

  task automatic send_file();
    foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
    bytes_sent += file_bytes.size();
    file_bytes.delete();
  endtask

  task automatic add_byte(logic [7:0] b);
    file_bytes = {file_bytes, b};
  endtask

  task automatic add_tag();
    for (int unsigned i = 0; i < TagLen; i++) add_byte(file_tag_char(i));
  endtask

  task automatic add_length(logic [31:0] len);
    for (int i = 0; i < 4; i++) add_byte(len[8 * i +: 8]);
  endtask

  task automatic add_junk(int unsigned n);
    repeat (n) begin
      if ($urandom_range(0, 2) == 0)
        add_byte(file_tag_char($urandom_range(0, TagLen - 1)));
      else
        add_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic add_block(int unsigned len);
    add_tag();
    add_length(len);
    repeat (len) add_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic build_file();
    int unsigned kind;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      add_junk($urandom_range(1, 9));
    end else if (kind < 20) begin
      add_junk($urandom_range(5, 30));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 2) == 0) add_junk($urandom_range(1, 4));
        add_block(($urandom_range(0, 19) == 0) ? $urandom_range(40, 200)
                                               : $urandom_range(0, 12));
      end
      if (kind < 32) begin
        add_tag();
        add_length($urandom());
        add_junk($urandom_range(0, 6));
      end else if (kind < 44) begin
        add_tag();
        add_length($urandom());
        repeat ($urandom_range(1, 9)) void'(file_bytes.pop_back());
      end else if ($urandom_range(0, 3) == 0) begin
        add_junk($urandom_range(1, 5));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    file_bytes = '{8'h00, 8'hFF, 8'h42};
    send_file();
    add_tag();
    add_length(32'd0);
    send_file();
    add_byte(file_tag_char(0));
    add_tag();
    add_length(32'd1);
    add_byte(8'hFF);
    send_file();

    while (bytes_sent < TargetBytes) begin
      quiet = ($urandom_range(0, 5) == 0);
      build_file();
      send_file();
    end
    quiet = 1'b0;
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("tagged_block_stream_parser regression: pass");
    end else begin
      $display("tagged_block_stream_parser regression: fail");
    end
    $finish;
  end
endmodule

[sim.f]
rtl/core/tbsp_pkg.sv
rtl/core/tagged_block_stream_parser.sv
rtl/core/tbsp_checker.sv
tb/sv/testbench.sv
